FILE: hdl/point_to_end_segment_distance_core_defines.svh
// Assertion macros for the point to end segment distance core.
// Included by the RTL files that carry concurrent assertions; no other dependencies.
`ifndef POINT_TO_END_SEGMENT_DISTANCE_CORE_DEFINES_SVH
`define POINT_TO_END_SEGMENT_DISTANCE_CORE_DEFINES_SVH

// Assertion on an explicit clock and active-low reset.
`define PTESD_ASSERT_AT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assertion on the standard clock and reset of this design.
`define PTESD_ASSERT(lbl, prop, msg) \
  `PTESD_ASSERT_AT(lbl, clk_i, rst_ni, prop, msg)

`endif

FILE: hdl/ptesd_pkg.sv
// Shared types and constants of the point to end segment distance core.
// Used by every module of the core; depends on nothing.
`default_nettype none

package ptesd_pkg;

  // Depth of the queue between the front and the back.
  localparam int DEPTH = 4;
  // Bits of the internal projection fraction (0 .. 2^32).
  localparam int QW = 33;
  // Radicand width and number of root digits.
  localparam int RW = 62;
  localparam int SW = RW / 2;

  localparam logic [29:0] SENTINEL = 30'd655360000;
  localparam logic [61:0] SAT2     = 62'd429496729600000000;
  localparam logic [16:0] COEF_ONE = 17'd65536;
  localparam logic [30:0] SEG_RESET = 31'd65536;

  typedef enum logic [1:0] {
    ST_INTERIOR = 2'd0,
    ST_START    = 2'd1,
    ST_END      = 2'd2,
    ST_UNREACH  = 2'd3
  } ptesd_status_e;

  typedef struct packed {
    logic signed [31:0] query_x;
    logic signed [31:0] query_y;
    logic signed [31:0] query_z;
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic signed [31:0] start_z;
    logic signed [31:0] end_x;
    logic signed [31:0] end_y;
    logic signed [31:0] end_z;
    logic               is_first_segment;
    logic               is_last_segment;
  } ptesd_in_t;

  typedef struct packed {
    logic [29:0] distance;
    logic [16:0] coefficient;
    logic [1:0]  status;
  } ptesd_out_t;

  // Classified item handed from the front to the back.
  typedef struct packed {
    logic signed [32:0] ax;
    logic signed [32:0] ay;
    logic signed [32:0] az;
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    logic signed [32:0] dz;
    logic [61:0]        dot;
    ptesd_status_e      status;
  } ptesd_work_t;

  // Item after the projection fraction is known.
  typedef struct packed {
    logic signed [32:0] ax;
    logic signed [32:0] ay;
    logic signed [32:0] az;
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    logic signed [32:0] dz;
    logic [QW-1:0]      frac;
    ptesd_status_e      status;
  } ptesd_prj_t;

endpackage

`default_nettype wire

FILE: hdl/ptesd_front.sv
// Front of the core: differences, dot product and classification of each beat.
// Depends on ptesd_pkg.
`default_nettype none

module ptesd_front (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  ptesd_pkg::ptesd_in_t   in_i,
  input  logic                   push_i,
  output logic                   full_o,
  input  logic [61:0]            l2_i,
  output ptesd_pkg::ptesd_work_t work_o,
  output logic                   work_valid_o,
  input  logic                   work_ready_i
);
  import ptesd_pkg::*;

  logic adv;
  logic v1_q, v2_q, v3_q;

  // Stage 1 registers: difference vectors.
  logic signed [32:0] ax_q, ay_q, az_q, dx_q, dy_q, dz_q, bx_q, by_q, bz_q;
  logic first1_q, last1_q;
  // Stage 2 registers: products.
  logic signed [65:0] px_q, py_q, pz_q;
  logic signed [32:0] ax2_q, ay2_q, az2_q, dx2_q, dy2_q, dz2_q, bx2_q, by2_q, bz2_q;
  logic first2_q, last2_q;
  // Stage 3 register: classified item.
  ptesd_work_t work_q, work_d;

  logic signed [67:0] dot_sum;
  logic               dot_neg, dot_gt;

  // The whole front moves when its last stage is empty or drains.
  assign adv    = !v3_q || work_ready_i;
  assign full_o = !adv;

  // Valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (adv) begin
      v1_q <= push_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // Stage 1: relative vectors to start and end.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      ax_q <= {in_i.query_x[31], in_i.query_x} - {in_i.start_x[31], in_i.start_x};
      ay_q <= {in_i.query_y[31], in_i.query_y} - {in_i.start_y[31], in_i.start_y};
      az_q <= {in_i.query_z[31], in_i.query_z} - {in_i.start_z[31], in_i.start_z};
      dx_q <= {in_i.end_x[31], in_i.end_x} - {in_i.start_x[31], in_i.start_x};
      dy_q <= {in_i.end_y[31], in_i.end_y} - {in_i.start_y[31], in_i.start_y};
      dz_q <= {in_i.end_z[31], in_i.end_z} - {in_i.start_z[31], in_i.start_z};
      bx_q <= {in_i.query_x[31], in_i.query_x} - {in_i.end_x[31], in_i.end_x};
      by_q <= {in_i.query_y[31], in_i.query_y} - {in_i.end_y[31], in_i.end_y};
      bz_q <= {in_i.query_z[31], in_i.query_z} - {in_i.end_z[31], in_i.end_z};
      first1_q <= in_i.is_first_segment;
      last1_q  <= in_i.is_last_segment;
    end
  end

  // Stage 2: one multiplier per axis for the dot product.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      px_q  <= ax_q * dx_q;
      py_q  <= ay_q * dy_q;
      pz_q  <= az_q * dz_q;
      ax2_q <= ax_q;
      ay2_q <= ay_q;
      az2_q <= az_q;
      dx2_q <= dx_q;
      dy2_q <= dy_q;
      dz2_q <= dz_q;
      bx2_q <= bx_q;
      by2_q <= by_q;
      bz2_q <= bz_q;
      first2_q <= first1_q;
      last2_q  <= last1_q;
    end
  end

  // Stage 3: sum the products and decide where the point projects.
  always_comb begin
    dot_sum = {{2{px_q[65]}}, px_q} + {{2{py_q[65]}}, py_q} + {{2{pz_q[65]}}, pz_q};
    dot_neg = dot_sum[67];
    dot_gt  = !dot_neg && (dot_sum > $signed({6'b0, l2_i}));
    work_d.ax     = ax2_q;
    work_d.ay     = ay2_q;
    work_d.az     = az2_q;
    work_d.dx     = '0;
    work_d.dy     = '0;
    work_d.dz     = '0;
    work_d.dot    = '0;
    if (dot_neg) begin
      work_d.status = first2_q ? ST_START : ST_UNREACH;
    end else if (dot_gt) begin
      work_d.status = last2_q ? ST_END : ST_UNREACH;
      work_d.ax     = bx2_q;
      work_d.ay     = by2_q;
      work_d.az     = bz2_q;
    end else begin
      work_d.status = ST_INTERIOR;
      work_d.dx     = dx2_q;
      work_d.dy     = dy2_q;
      work_d.dz     = dz2_q;
      work_d.dot    = dot_sum[61:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      work_q <= work_d;
    end
  end

  assign work_o       = work_q;
  assign work_valid_o = v3_q;

endmodule

`default_nettype wire

FILE: hdl/ptesd_fifo.sv
// Short queue that decouples the front from the back of the core.
// Depends on ptesd_pkg and the assertion macro header.
`default_nettype none
`include "point_to_end_segment_distance_core_defines.svh"

module ptesd_fifo (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  ptesd_pkg::ptesd_work_t wr_data_i,
  input  logic                   wr_valid_i,
  output logic                   wr_ready_o,
  output ptesd_pkg::ptesd_work_t rd_data_o,
  output logic                   rd_valid_o,
  input  logic                   rd_pop_i
);
  import ptesd_pkg::*;

  localparam int AW = $clog2(DEPTH);

  ptesd_work_t          mem_q [DEPTH];
  logic [AW-1:0]        wr_ptr_q, rd_ptr_q;
  logic [AW:0]          cnt_q, cnt_d;
  logic                 do_wr, do_rd;

  assign wr_ready_o = (cnt_q != (AW+1)'(DEPTH));
  assign rd_valid_o = (cnt_q != '0);
  assign do_wr      = wr_valid_i && wr_ready_o;
  assign do_rd      = rd_pop_i && rd_valid_o;
  assign rd_data_o  = mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      cnt_q <= cnt_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  `PTESD_ASSERT(a_cnt_bound, cnt_q <= (AW+1)'(DEPTH), "queue count above depth")
  `PTESD_ASSERT(a_cnt_up, do_wr && !do_rd |=> cnt_q == $past(cnt_q) + 1'b1, "count missed a write")
  `PTESD_ASSERT(a_ptr_gap, (AW)'(wr_ptr_q - rd_ptr_q) == cnt_q[AW-1:0], "pointers disagree with count")

endmodule

`default_nettype wire

FILE: hdl/ptesd_div.sv
// Pipelined restoring divider forming the projection fraction dot * 2^32 / L2.
// One quotient bit per stage; depends on ptesd_pkg.
`default_nettype none

module ptesd_div (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   in_valid_i,
  input  ptesd_pkg::ptesd_work_t work_i,
  input  logic [61:0]            l2_i,
  output ptesd_pkg::ptesd_prj_t  prj_o,
  output logic                   valid_o
);
  import ptesd_pkg::*;

  typedef struct packed {
    logic signed [32:0] ax;
    logic signed [32:0] ay;
    logic signed [32:0] az;
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    logic signed [32:0] dz;
    ptesd_status_e      status;
  } div_pay_t;

  logic [61:0]   rem_q [QW];
  logic [QW-1:0] quo_q [QW];
  div_pay_t      pay_q [QW];
  logic [QW-1:0] v_q;
  logic          l2_nz;
  logic          bit0;

  assign l2_nz = (l2_i != '0);
  assign bit0  = l2_nz && (work_i.dot >= l2_i);

  // Valid bits of all stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[QW-2:0], in_valid_i};
    end
  end

  // First stage: the integer quotient bit (set only when dot equals L2).
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]        <= bit0 ? work_i.dot - l2_i : work_i.dot;
      quo_q[0]        <= {{(QW-1){1'b0}}, bit0};
      pay_q[0].ax     <= work_i.ax;
      pay_q[0].ay     <= work_i.ay;
      pay_q[0].az     <= work_i.az;
      pay_q[0].dx     <= work_i.dx;
      pay_q[0].dy     <= work_i.dy;
      pay_q[0].dz     <= work_i.dz;
      pay_q[0].status <= work_i.status;
    end
  end

  // Remaining stages: one fractional bit each.
  for (genvar k = 1; k < QW; k++) begin : g_stage
    logic [62:0] trial;
    logic        qbit;
    logic [62:0] diff;

    assign trial = {rem_q[k-1], 1'b0};
    assign qbit  = l2_nz && (trial >= {1'b0, l2_i});
    assign diff  = trial - {1'b0, l2_i};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= qbit ? diff[61:0] : trial[61:0];
        quo_q[k] <= {quo_q[k-1][QW-2:0], qbit};
        pay_q[k] <= pay_q[k-1];
      end
    end
  end

  assign prj_o.ax     = pay_q[QW-1].ax;
  assign prj_o.ay     = pay_q[QW-1].ay;
  assign prj_o.az     = pay_q[QW-1].az;
  assign prj_o.dx     = pay_q[QW-1].dx;
  assign prj_o.dy     = pay_q[QW-1].dy;
  assign prj_o.dz     = pay_q[QW-1].dz;
  assign prj_o.frac   = quo_q[QW-1];
  assign prj_o.status = pay_q[QW-1].status;
  assign valid_o      = v_q[QW-1];

endmodule

`default_nettype wire

FILE: hdl/ptesd_norm.sv
// Perpendicular vector, saturated sum of squares and pipelined square root.
// The last stage is the result register; depends on ptesd_pkg.
`default_nettype none

module ptesd_norm (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  in_valid_i,
  input  ptesd_pkg::ptesd_prj_t prj_i,
  output ptesd_pkg::ptesd_out_t res_o,
  output logic                  valid_o
);
  import ptesd_pkg::*;

  localparam int NPRE = 4;

  logic [NPRE-1:0] vp_q;
  logic [SW-1:0]   vs_q;

  // Stage 1: scaled direction, one multiplier per axis.
  logic signed [66:0] mx_q, my_q, mz_q;
  logic signed [32:0] ax1_q, ay1_q, az1_q;
  logic [16:0]        coef1_q, coef1_d;
  ptesd_status_e      st1_q;
  // Stage 2: perpendicular components.
  logic signed [35:0] vx_q, vy_q, vz_q;
  logic [16:0]        coef2_q;
  ptesd_status_e      st2_q;
  // Stage 3: squares.
  logic [59:0]        sx_q, sy_q, sz_q;
  logic               sat3_q;
  logic [16:0]        coef3_q;
  ptesd_status_e      st3_q;
  // Stage 4: radicand.
  logic [RW-1:0]      rad_q;
  logic               sat4_q;
  logic [16:0]        coef4_q;
  ptesd_status_e      st4_q;

  logic signed [67:0] tx, ty, tz;
  logic [34:0]        magx, magy, magz;
  logic [61:0]        sum_sq;

  // Valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vp_q <= '0;
      vs_q <= '0;
    end else if (en_i) begin
      vp_q <= {vp_q[NPRE-2:0], in_valid_i};
      vs_q <= {vs_q[SW-2:0], vp_q[NPRE-1]};
    end
  end

  // Reported coefficient by case.
  always_comb begin
    case (prj_i.status)
      ST_INTERIOR: coef1_d = prj_i.frac[QW-1:16];
      ST_END:      coef1_d = COEF_ONE;
      default:     coef1_d = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mx_q    <= $signed({1'b0, prj_i.frac}) * prj_i.dx;
      my_q    <= $signed({1'b0, prj_i.frac}) * prj_i.dy;
      mz_q    <= $signed({1'b0, prj_i.frac}) * prj_i.dz;
      ax1_q   <= prj_i.ax;
      ay1_q   <= prj_i.ay;
      az1_q   <= prj_i.az;
      coef1_q <= coef1_d;
      st1_q   <= prj_i.status;
    end
  end

  // Stage 2: subtract the rounded projection (halves round up).
  assign tx = {mx_q[66], mx_q} + 68'sd2147483648;
  assign ty = {my_q[66], my_q} + 68'sd2147483648;
  assign tz = {mz_q[66], mz_q} + 68'sd2147483648;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      vx_q    <= {{3{ax1_q[32]}}, ax1_q} - tx[67:32];
      vy_q    <= {{3{ay1_q[32]}}, ay1_q} - ty[67:32];
      vz_q    <= {{3{az1_q[32]}}, az1_q} - tz[67:32];
      coef2_q <= coef1_q;
      st2_q   <= st1_q;
    end
  end

  // Stage 3: magnitudes; a component at or above 2^30 saturates on its own.
  assign magx = vx_q[35] ? 35'(-vx_q) : vx_q[34:0];
  assign magy = vy_q[35] ? 35'(-vy_q) : vy_q[34:0];
  assign magz = vz_q[35] ? 35'(-vz_q) : vz_q[34:0];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sx_q    <= magx[29:0] * magx[29:0];
      sy_q    <= magy[29:0] * magy[29:0];
      sz_q    <= magz[29:0] * magz[29:0];
      sat3_q  <= (|magx[34:30]) || (|magy[34:30]) || (|magz[34:30]) ||
                 (st2_q == ST_UNREACH);
      coef3_q <= coef2_q;
      st3_q   <= st2_q;
    end
  end

  // Stage 4: sum of squares and saturation check.
  assign sum_sq = {2'b0, sx_q} + {2'b0, sy_q} + {2'b0, sz_q};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rad_q   <= sum_sq;
      sat4_q  <= sat3_q || (sum_sq >= SAT2);
      coef4_q <= coef3_q;
      st4_q   <= st3_q;
    end
  end

  // Square root: one root digit per stage.
  logic [33:0]   rem_q  [SW];
  logic [SW-1:0] root_q [SW];
  logic [RW-1:0] xs_q   [SW];
  logic          sat_q  [SW];
  logic [16:0]   coef_q [SW];
  ptesd_status_e st_q   [SW];

  for (genvar k = 0; k < SW; k++) begin : g_root
    logic [33:0]   rem_prev;
    logic [SW-1:0] root_prev;
    logic [RW-1:0] xs_prev;
    logic [33:0]   trial;
    logic [33:0]   cand;
    logic          ge;

    if (k == 0) begin : g_first
      assign rem_prev  = '0;
      assign root_prev = '0;
      assign xs_prev   = rad_q;
    end else begin : g_next
      assign rem_prev  = rem_q[k-1];
      assign root_prev = root_q[k-1];
      assign xs_prev   = xs_q[k-1];
    end

    assign trial = {rem_prev[31:0], xs_prev[RW-1:RW-2]};
    assign cand  = {1'b0, root_prev, 2'b01};
    assign ge    = (trial >= cand);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= ge ? trial - cand : trial;
        root_q[k] <= {root_prev[SW-2:0], ge};
        xs_q[k]   <= {xs_prev[RW-3:0], 2'b00};
        if (k == 0) begin
          sat_q[k]  <= sat4_q;
          coef_q[k] <= coef4_q;
          st_q[k]   <= st4_q;
        end else begin
          sat_q[k]  <= sat_q[k-1];
          coef_q[k] <= coef_q[k-1];
          st_q[k]   <= st_q[k-1];
        end
      end
    end
  end

  assign res_o.distance    = sat_q[SW-1] ? SENTINEL : root_q[SW-1][29:0];
  assign res_o.coefficient = coef_q[SW-1];
  assign res_o.status      = st_q[SW-1];
  assign valid_o           = vs_q[SW-1];

endmodule

`default_nettype wire

FILE: hdl/point_to_end_segment_distance_core.sv
// Top level of the point to end segment distance core.
// Depends on ptesd_pkg, ptesd_front, ptesd_fifo, ptesd_div, ptesd_norm and the macro header.
`default_nettype none
`include "point_to_end_segment_distance_core_defines.svh"

// Distance from a 3D point to one segment of a chain, Q16.16 in and out. The core takes
// one beat per clock while full_o is low and returns one result beat per input in order.
// From push to result, a beat passes the three front stages, the queue, 33 divider stages
// (one quotient bit per stage) and 35 norm stages (31 of them the square root, one root
// digit per stage). The front keeps accepting while the back is stalled until the
// four-entry queue fills. A write to segment_length reaches new beats through the
// registered seg_q and then its registered square l2_q.
module point_to_end_segment_distance_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ptesd_pkg::ptesd_in_t  in_i,
  input  logic                  push_i,
  output logic                  full_o,
  output ptesd_pkg::ptesd_out_t out_o,
  output logic                  empty_o,
  input  logic                  pop_i,
  input  logic                  cfg_we_i,
  input  logic [31:0]           cfg_wdata_i
);
  import ptesd_pkg::*;

  logic [30:0]  seg_q;
  logic [61:0]  l2_q;
  ptesd_work_t  fr_work, q_work;
  logic         fr_valid, fr_ready, q_valid;
  logic         back_adv, q_pop;
  ptesd_prj_t   prj;
  logic         prj_valid, out_valid;

  // Segment length register and its square.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_q <= SEG_RESET;
      l2_q  <= 62'(SEG_RESET) * 62'(SEG_RESET);
    end else begin
      if (cfg_we_i) begin
        seg_q <= cfg_wdata_i[30:0];
      end
      l2_q <= seg_q * seg_q;
    end
  end

  ptesd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .push_i       (push_i),
    .full_o       (full_o),
    .l2_i         (l2_q),
    .work_o       (fr_work),
    .work_valid_o (fr_valid),
    .work_ready_i (fr_ready)
  );

  ptesd_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_data_i  (fr_work),
    .wr_valid_i (fr_valid),
    .wr_ready_o (fr_ready),
    .rd_data_o  (q_work),
    .rd_valid_o (q_valid),
    .rd_pop_i   (q_pop)
  );

  // The back moves as a whole when the result register is free or being popped.
  assign back_adv = !out_valid || pop_i;
  assign q_pop    = back_adv && q_valid;

  ptesd_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (back_adv),
    .in_valid_i (q_pop),
    .work_i     (q_work),
    .l2_i       (l2_q),
    .prj_o      (prj),
    .valid_o    (prj_valid)
  );

  ptesd_norm u_norm (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (back_adv),
    .in_valid_i (prj_valid),
    .prj_i      (prj),
    .res_o      (out_o),
    .valid_o    (out_valid)
  );

  assign empty_o = !out_valid;

  `PTESD_ASSERT(a_unreach_sentinel, !empty_o && out_o.status == ST_UNREACH |-> out_o.distance == SENTINEL && out_o.coefficient == '0, "unreachable result not sentinel")
  `PTESD_ASSERT(a_end_coef, !empty_o && out_o.status == ST_END |-> out_o.coefficient == COEF_ONE, "end result coefficient not one")
  `PTESD_ASSERT(a_coef_range, !empty_o |-> out_o.coefficient <= COEF_ONE && out_o.distance <= SENTINEL, "result out of range")

endmodule

`default_nettype wire
